>>> design/usf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 sequence filter package
// Shared constants, result and state types for the UTF-8 sequence filter.
// ----------------------------------------------------------------------------
package usf_pkg;

  // Byte classification masks and patterns.
  localparam logic [7:0] ASCII_MAX  = 8'h7F;
  localparam logic [7:0] CONT_MASK  = 8'hC0;
  localparam logic [7:0] CONT_PAT   = 8'h80;
  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_PAT  = 8'hC0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_PAT  = 8'hE0;
  localparam logic [7:0] LEAD4_MASK = 8'hF8;
  localparam logic [7:0] LEAD4_PAT  = 8'hF0;

  // Continuation bytes still missing after each kind of lead byte.
  localparam logic [1:0] NEED_NONE = 2'd0;
  localparam logic [1:0] NEED_ONE  = 2'd1;
  localparam logic [1:0] NEED_TWO  = 2'd2;
  localparam logic [1:0] NEED_THREE = 2'd3;

  // Held sequence store and result burst sizes.
  localparam int HELD_DEPTH  = 3;
  localparam int MAX_RESULTS = 4;
  localparam int NUM_W       = $clog2(MAX_RESULTS + 1);

  // Result queue geometry (depth is a power of two).
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  // One result item.
  typedef struct packed {
    logic [7:0] data;
    logic       present;
    logic       eom;
    logic       run_last;
  } result_t;

  typedef result_t [MAX_RESULTS-1:0] result_burst_t;

  typedef logic [HELD_DEPTH-1:0][7:0] held_arr_t;

  // Sequence tracking counters.
  typedef struct packed {
    logic [1:0] held_count;
    logic [1:0] needed_count;
  } seq_state_t;

  // Write request into the held byte store.
  typedef struct packed {
    logic       we;
    logic [1:0] idx;
  } held_wr_t;

endpackage

>>> design/utf8_sequence_filter_unit.sv
// Path: an accepted item sits in the input register, then its results go into the result queue.
// Throughput: one input item per cycle, processed only when four result queue slots are free;
// results leave one per cycle, while out_ready is high, from the eight-entry result queue.
// Reset: synchronous, active low; clears the sequence counters and the queue,
// while the held byte store stays undefined until written.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 sequence filter
// Keeps well-formed UTF-8 sequences of a byte stream, drops broken and stray
// bytes, and marks the end of each message on the output.
// ----------------------------------------------------------------------------
module utf8_sequence_filter_unit
  import usf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_message_end,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_out_byte,
  output logic       out_byte_present,
  output logic       out_end_of_message,
  output logic       out_run_last
);

  logic             ir_valid_r;
  logic [7:0]       ir_byte_r;
  logic             ir_last_r;
  seq_state_t       state_r;
  seq_state_t       state_nxt;
  held_arr_t        held_r;
  held_wr_t         held_wr;
  result_burst_t    burst;
  logic [NUM_W-1:0] burst_num;
  logic             fifo_space;
  logic             proc_fire;
  result_t          head;

  // Input register: refilled whenever its item moves on.
  assign proc_fire = ir_valid_r && fifo_space;
  assign in_ready  = !ir_valid_r || proc_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ir_valid_r <= 1'b0;
    end else if (in_ready) begin
      ir_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      ir_byte_r <= in_data_byte;
      ir_last_r <= in_message_end;
    end
  end

  // Sequence classification and result burst.
  usf_decode u_decode (
    .data_byte   (ir_byte_r),
    .message_end (ir_last_r),
    .cur_state   (state_r),
    .held        (held_r),
    .nxt_state   (state_nxt),
    .held_wr     (held_wr),
    .results     (burst),
    .result_num  (burst_num)
  );

  // Sequence counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (proc_fire) begin
      state_r <= state_nxt;
    end
  end

  // Held lead and continuation bytes.
  always_ff @(posedge clk) begin
    if (proc_fire && held_wr.we) begin
      held_r[held_wr.idx] <= ir_byte_r;
    end
  end

  // Result queue feeding the output channel.
  usf_result_fifo u_result_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_data  (burst),
    .wr_num   (proc_fire ? burst_num : NUM_W'(0)),
    .wr_space (fifo_space),
    .rd_data  (head),
    .rd_valid (out_valid),
    .rd_ready (out_ready)
  );

  assign out_out_byte       = head.data;
  assign out_byte_present   = head.present;
  assign out_end_of_message = head.eom;
  assign out_run_last       = head.run_last;

`ifndef SYNTH
  // An open sequence always has its lead byte held.
  a_open_has_lead: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.needed_count != NEED_NONE) |-> (state_r.held_count != 2'd0))
    else $error("open sequence without a held lead byte");

  // The end of a message leaves no sequence open.
  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (proc_fire && ir_last_r) |=> (state_r == '0))
    else $error("sequence state not cleared at end of message");

  // The last byte of a message always produces at least one item.
  a_end_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (proc_fire && ir_last_r) |-> (burst_num != '0))
    else $error("end of message produced no item");
`endif

endmodule

>>> design/usf_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 sequence filter decode
// Classifies one byte against the open sequence and produces the next
// sequence state, the held store write and the burst of result items.
// ----------------------------------------------------------------------------
module usf_decode
  import usf_pkg::*;
(
  input  logic [7:0]         data_byte,
  input  logic               message_end,
  input  seq_state_t         cur_state,
  input  held_arr_t          held,
  output seq_state_t         nxt_state,
  output held_wr_t           held_wr,
  output result_burst_t      results,
  output logic [NUM_W-1:0]   result_num
);

  logic       is_cont;
  logic       is_ascii;
  logic       is_lead2;
  logic       is_lead3;
  logic       is_lead4;
  logic       seq_open;
  logic       extend;
  logic       complete;
  logic       emit;
  logic [1:0] flush_cnt;
  logic [NUM_W-1:0] num_bytes;

  // Byte classification.
  assign is_cont  = (data_byte & CONT_MASK) == CONT_PAT;
  assign is_ascii = data_byte <= ASCII_MAX;
  assign is_lead2 = (data_byte & LEAD2_MASK) == LEAD2_PAT;
  assign is_lead3 = (data_byte & LEAD3_MASK) == LEAD3_PAT;
  assign is_lead4 = (data_byte & LEAD4_MASK) == LEAD4_PAT;

  // A continuation either completes the open sequence or extends it.
  assign seq_open = cur_state.needed_count != NEED_NONE;
  assign extend   = seq_open && is_cont;
  assign complete = extend && (cur_state.needed_count == NEED_ONE);
  assign emit     = complete || (!extend && is_ascii);
  assign flush_cnt = complete ? cur_state.held_count : 2'd0;
  assign num_bytes = emit ? (NUM_W'(flush_cnt) + NUM_W'(1)) : '0;

  // Next sequence state and held store write.
  always_comb begin
    nxt_state  = '0;
    held_wr.we  = 1'b0;
    held_wr.idx = 2'd0;
    if (extend) begin
      if (!complete) begin
        held_wr.we  = 1'b1;
        held_wr.idx = cur_state.held_count;
        nxt_state.held_count   = cur_state.held_count + 2'd1;
        nxt_state.needed_count = cur_state.needed_count - 2'd1;
      end
    end else if (!is_ascii) begin
      if (is_lead2 || is_lead3 || is_lead4) begin
        held_wr.we  = 1'b1;
        held_wr.idx = 2'd0;
        nxt_state.held_count = 2'd1;
      end
      if (is_lead2) begin
        nxt_state.needed_count = NEED_ONE;
      end else if (is_lead3) begin
        nxt_state.needed_count = NEED_TWO;
      end else if (is_lead4) begin
        nxt_state.needed_count = NEED_THREE;
      end
    end
    // The end of the message drops any open sequence.
    if (message_end) begin
      nxt_state = '0;
    end
  end

  // Result burst: flushed held bytes first, then the current byte.
  always_comb begin
    results[0].data = (flush_cnt > 2'd0) ? held[0] : data_byte;
    results[1].data = (flush_cnt > 2'd1) ? held[1] : data_byte;
    results[2].data = (flush_cnt > 2'd2) ? held[2] : data_byte;
    results[3].data = data_byte;
    result_num = num_bytes;
    for (int i = 0; i < MAX_RESULTS; i++) begin
      results[i].present = 1'b1;
    end
    // An end of message with no byte still yields an empty marker item.
    if (message_end && (num_bytes == '0)) begin
      result_num         = NUM_W'(1);
      results[0].data    = 8'd0;
      results[0].present = 1'b0;
    end
    for (int i = 0; i < MAX_RESULTS; i++) begin
      results[i].run_last = NUM_W'(i) == (result_num - NUM_W'(1));
      results[i].eom      = message_end && results[i].run_last;
    end
  end

endmodule

>>> design/usf_result_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 sequence filter result queue
// Accepts a burst of up to four result items per cycle and presents them
// one at a time on a valid/ready output.
// ----------------------------------------------------------------------------
module usf_result_fifo
  import usf_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  result_burst_t    wr_data,
  input  logic [NUM_W-1:0] wr_num,
  output logic             wr_space,
  output result_t          rd_data,
  output logic             rd_valid,
  input  logic             rd_ready
);

  result_t              mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr_r;
  logic [FIFO_AW-1:0]   wr_ptr_nxt;
  logic [FIFO_AW-1:0]   rd_ptr_r;
  logic [FIFO_AW-1:0]   rd_ptr_nxt;
  logic [FIFO_CW-1:0]   count_r;
  logic [FIFO_CW-1:0]   count_nxt;
  logic                 rd_fire;

  // Room for a full burst is required before a new item is processed.
  assign wr_space = count_r <= FIFO_CW'(FIFO_DEPTH - MAX_RESULTS);
  assign rd_valid = count_r != '0;
  assign rd_data  = mem_r[rd_ptr_r];
  assign rd_fire  = rd_valid && rd_ready;

  assign wr_ptr_nxt = wr_ptr_r + FIFO_AW'(wr_num);
  assign rd_ptr_nxt = rd_ptr_r + FIFO_AW'(rd_fire);
  assign count_nxt  = count_r + FIFO_CW'(wr_num) - FIFO_CW'(rd_fire);

  // Storage: burst entries land at consecutive slots.
  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_RESULTS; i++) begin
      if (NUM_W'(i) < wr_num) begin
        mem_r[wr_ptr_r + FIFO_AW'(i)] <= wr_data[i];
      end
    end
  end

  // Pointers and occupancy.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule
